@@ design/rdst_pkg.sv @@
// Shared types, constants and helpers for the recent device seen table.
// No dependencies; compiled first.
`default_nettype none

package rdst_pkg;

    // Table geometry
    localparam int TABLE_DEPTH   = 32;
    localparam int ADDRESS_BYTES = 6;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W        = 48;
    localparam int IDENT_W       = 16;
    localparam int ENTRY_W       = ADDR_W + IDENT_W;

    // Only the low ADDRESS_BYTES address bytes take part in a compare (all six here)
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BYTES >= 6) ? '1 :
        ((ADDR_W'(1) << (8 * ADDRESS_BYTES)) - ADDR_W'(1));

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USED     = 3'd0,
        CFG_VISITED  = 3'd1,
        CFG_SETTABLE = 3'd2,
        CFG_TYPE     = 3'd3,
        CFG_BADGE    = 3'd4,
        CFG_PEER     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] used_mask;
        logic [7:0] visited_mask;
        logic [7:0] settable_mask;
        logic [7:0] type_mask;
        logic [7:0] badge_type_code;
        logic [7:0] peer_type_code;
    } t_cfg;

    // Input kinds
    typedef enum logic [1:0] {
        KIND_CHECK = 2'd0,
        KIND_SET   = 2'd1,
        KIND_COUNT = 2'd2
    } t_kind;

    // Decoded operation
    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_SET   = 2'd1,
        OP_COUNT = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_ADDED  = 2'd1,
        ST_ABSENT = 2'd2,
        ST_COUNT  = 2'd3
    } t_status;

    // Classified command word
    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [IDENT_W-1:0] ident;
        logic               is_badge;
        logic               is_peer;
        logic               contacted;
        logic [7:0]         request_flags;
    } t_cmd;

    // Slot number as the 5-bit result field
    function automatic logic [4:0] idx_out(input logic [IDX_W-1:0] i);
        logic [8:0] w;
        w = 9'(i);
        return w[4:0];
    endfunction

    // Used count as the 6-bit result field
    function automatic logic [5:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [9:0] w;
        w = 10'(c);
        return w[5:0];
    endfunction

    // Walk one slot toward older entries, wrapping
    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] p);
        return (p == '0) ? IDX_W'(TABLE_DEPTH - 1) : p - 1'b1;
    endfunction

    // Advance the write pointer, wrapping
    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(TABLE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ design/rdst_if.sv @@
// Channel interfaces: input words, result words and configuration writes.
// Standalone; compiled after rdst_pkg.
`default_nettype none

interface rdst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [47:0] device_address;
    logic [15:0] device_ident;
    logic [7:0]  device_type;
    logic        contacted;
    logic [7:0]  request_flags;

    modport source (output valid, kind, device_address, device_ident, device_type,
                    contacted, request_flags, input ready);
    modport sink   (input valid, kind, device_address, device_ident, device_type,
                    contacted, request_flags, output ready);
endinterface

interface rdst_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] flags_out;
    logic [4:0] entry_index;
    logic [5:0] used_count;

    modport source (output valid, status, flags_out, entry_index, used_count,
                    input ready);
    modport sink   (input valid, status, flags_out, entry_index, used_count,
                    output ready);
endinterface

interface rdst_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] reg_index;
    logic [7:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

@@ design/rdst_front.sv @@
// Front end: accepts input words, decodes the kind and classifies the type.
// Depends on rdst_pkg and rdst_in_if.
`default_nettype none

module rdst_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rdst_in_if.sink            i_in,
    input  wire rdst_pkg::t_cfg i_cfg,
    output logic               o_push_vld,
    output rdst_pkg::t_cmd     o_push_cmd,
    input  wire logic          i_push_rdy
);
    import rdst_pkg::*;

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    // Holding stage frees up as soon as the queue takes its word
    assign i_in.ready = !r_vld || i_push_rdy;
    assign take       = i_in.valid && i_in.ready;

    // Decode and classify
    always_comb begin
        n_cmd               = '0;
        case (t_kind'(i_in.kind))
            KIND_CHECK: n_cmd.op = OP_CHECK;
            KIND_SET:   n_cmd.op = OP_SET;
            KIND_COUNT: n_cmd.op = OP_COUNT;
            default:    n_cmd.op = OP_NONE;
        endcase
        n_cmd.addr          = i_in.device_address & ADDR_MASK;
        n_cmd.ident         = i_in.device_ident;
        n_cmd.is_badge      = (i_in.device_type == i_cfg.badge_type_code);
        n_cmd.is_peer       = (i_in.device_type == i_cfg.peer_type_code);
        n_cmd.contacted     = i_in.contacted;
        n_cmd.request_flags = i_in.request_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_push_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_vld = r_vld;
    assign o_push_cmd = r_cmd;

endmodule

`default_nettype wire

@@ design/rdst_queue.sv @@
// Short command queue between front end and table engine.
// Depends on rdst_pkg.
`default_nettype none

module rdst_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_vld,
    input  wire rdst_pkg::t_cmd i_push_cmd,
    output logic                o_push_rdy,
    output logic                o_pop_vld,
    output rdst_pkg::t_cmd      o_pop_cmd,
    input  wire logic           i_pop_rdy
);
    import rdst_pkg::*;

    t_cmd               r_q [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               push;
    logic               pop;

    assign o_push_rdy = (r_cnt != Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_cnt != '0);
    assign o_pop_cmd  = r_q[r_rd];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/rdst_back.sv @@
// Table engine: holds the entry stores, scans newest first, updates the
// table and registers one result word per command. Depends on rdst_pkg and rdst_out_if.
`default_nettype none

module rdst_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rdst_pkg::t_cfg i_cfg,
    input  wire logic           i_pop_vld,
    input  wire rdst_pkg::t_cmd i_pop_cmd,
    output logic                o_pop_rdy,
    rdst_out_if.source          o_out
);
    import rdst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Entry stores
    logic [ENTRY_W-1:0] mem_entry [TABLE_DEPTH];
    logic [7:0]         mem_flags [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_fvalid;

    // Read side
    logic [ENTRY_W-1:0] r_eq;
    logic [7:0]         r_fq;
    logic               r_fq_vld;

    // Sequencer
    t_state             r_state,  n_state;
    t_cmd               r_cmd,    n_cmd;
    logic [IDX_W-1:0]   r_wp,     n_wp;
    logic [IDX_W-1:0]   r_pos,    n_pos;
    logic [CNT_W-1:0]   r_issued, n_issued;
    logic               r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]   r_chk_pos, n_chk_pos;
    logic [IDX_W-1:0]   r_used,   n_used;
    logic               r_hit,    n_hit;
    logic [IDX_W-1:0]   r_slot,   n_slot;
    logic [7:0]         r_hflags, n_hflags;
    logic [CNT_W-1:0]   r_count,  n_count;

    // Result register
    logic               r_out_vld, n_out_vld;
    t_status            r_status,  n_status;
    logic [7:0]         r_oflags,  n_oflags;
    logic [4:0]         r_oidx,    n_oidx;
    logic [5:0]         r_ocnt,    n_ocnt;

    // Store write controls
    logic               we_entry;
    logic               we_flags;
    logic [IDX_W-1:0]   wr_addr;
    logic [7:0]         wr_flags;

    logic               chk_used;
    logic               chk_match;
    logic               out_free;
    logic [7:0]         set_flags;

    assign out_free  = !r_out_vld || o_out.ready;
    assign chk_used  = r_fq_vld && ((r_fq & i_cfg.used_mask) != 8'd0);
    assign chk_match = (r_eq == {r_cmd.addr, r_cmd.ident});
    assign set_flags = r_hflags | (r_cmd.request_flags & i_cfg.settable_mask) |
                       i_cfg.used_mask;
    assign o_pop_rdy = (r_state == S_IDLE);

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_wp      = r_wp;
        n_pos     = r_pos;
        n_issued  = r_issued;
        n_chk_vld = r_chk_vld;
        n_chk_pos = r_chk_pos;
        n_used    = r_used;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_hflags  = r_hflags;
        n_count   = r_count;
        n_out_vld = r_out_vld && !o_out.ready;
        n_status  = r_status;
        n_oflags  = r_oflags;
        n_oidx    = r_oidx;
        n_ocnt    = r_ocnt;
        we_entry  = 1'b0;
        we_flags  = 1'b0;
        wr_addr   = r_wp;
        wr_flags  = 8'd0;

        case (r_state)
            // Take a command and start the walk at the newest entry
            S_IDLE: begin
                if (i_pop_vld) begin
                    n_cmd     = i_pop_cmd;
                    n_pos     = r_wp;
                    n_issued  = '0;
                    n_chk_vld = 1'b0;
                    n_used    = '0;
                    n_hit     = 1'b0;
                    n_count   = '0;
                    n_state   = (i_pop_cmd.op == OP_NONE) ? S_DONE : S_SCAN;
                end
            end

            // One read issued and one entry checked per cycle
            S_SCAN: begin
                n_chk_vld = (r_issued != CNT_W'(TABLE_DEPTH));
                n_chk_pos = r_pos;
                if (r_issued != CNT_W'(TABLE_DEPTH)) begin
                    n_pos    = step_back(r_pos);
                    n_issued = r_issued + 1'b1;
                end
                if (r_chk_vld) begin
                    if (!chk_used) begin
                        n_state = S_DONE;
                        n_count = CNT_W'(r_used);
                    end else if (r_cmd.op != OP_COUNT && chk_match) begin
                        n_state  = S_DONE;
                        n_hit    = 1'b1;
                        n_slot   = r_chk_pos;
                        n_hflags = r_fq;
                    end else if (r_used == IDX_W'(TABLE_DEPTH - 1)) begin
                        n_state = S_DONE;
                        n_count = CNT_W'(TABLE_DEPTH);
                    end else begin
                        n_used = r_used + 1'b1;
                    end
                end
            end

            // Apply the update and load the result word
            S_DONE: begin
                if (out_free) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_status  = ST_ABSENT;
                    n_oflags  = 8'd0;
                    n_oidx    = 5'd0;
                    n_ocnt    = 6'd0;
                    case (r_cmd.op)
                        OP_CHECK: begin
                            if (r_hit) begin
                                n_status = ST_FOUND;
                                n_oflags = r_hflags;
                                n_oidx   = idx_out(r_slot);
                            end else if (r_cmd.is_badge) begin
                                if (r_cmd.contacted) begin
                                    n_wp     = step_fwd(r_wp);
                                    we_entry = 1'b1;
                                    we_flags = 1'b1;
                                    wr_addr  = n_wp;
                                    wr_flags = i_cfg.used_mask | i_cfg.visited_mask |
                                               (i_cfg.badge_type_code & i_cfg.type_mask);
                                    n_status = ST_ADDED;
                                    n_oflags = i_cfg.used_mask | i_cfg.visited_mask;
                                    n_oidx   = idx_out(n_wp);
                                end
                            end else if (r_cmd.is_peer) begin
                                n_wp     = step_fwd(r_wp);
                                we_entry = 1'b1;
                                we_flags = 1'b1;
                                wr_addr  = n_wp;
                                wr_flags = i_cfg.used_mask |
                                           (i_cfg.peer_type_code & i_cfg.type_mask);
                                n_status = ST_ADDED;
                                n_oflags = i_cfg.used_mask;
                                n_oidx   = idx_out(n_wp);
                            end
                        end
                        OP_SET: begin
                            if (r_hit) begin
                                we_flags = 1'b1;
                                wr_addr  = r_slot;
                                wr_flags = set_flags;
                                n_status = ST_FOUND;
                                n_oflags = set_flags;
                                n_oidx   = idx_out(r_slot);
                            end
                        end
                        OP_COUNT: begin
                            n_status = ST_COUNT;
                            n_ocnt   = cnt_out(r_count);
                        end
                        default: begin
                            n_status = ST_ABSENT;
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_issued  <= '0;
            r_out_vld <= 1'b0;
            r_chk_vld <= 1'b0;
            r_fvalid  <= '0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_issued  <= n_issued;
            r_out_vld <= n_out_vld;
            r_chk_vld <= n_chk_vld;
            if (we_flags) begin
                r_fvalid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_pos     <= n_pos;
        r_chk_pos <= n_chk_pos;
        r_used    <= n_used;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        r_hflags  <= n_hflags;
        r_count   <= n_count;
        r_status  <= n_status;
        r_oflags  <= n_oflags;
        r_oidx    <= n_oidx;
        r_ocnt    <= n_ocnt;
    end

    // Entry stores: one write port, one registered read at the scan position
    always_ff @(posedge i_clk) begin
        if (we_entry) begin
            mem_entry[wr_addr] <= {r_cmd.addr, r_cmd.ident};
        end
        if (we_flags) begin
            mem_flags[wr_addr] <= wr_flags;
        end
        r_eq     <= mem_entry[r_pos];
        r_fq     <= mem_flags[r_pos];
        r_fq_vld <= r_fvalid[r_pos];
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_status;
    assign o_out.flags_out   = r_oflags;
    assign o_out.entry_index = r_oidx;
    assign o_out.used_count  = r_ocnt;

    // Walk never issues past the table depth
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued <= CNT_W'(TABLE_DEPTH))
        else $error("scan issued past table depth");

    // An entry under check was issued earlier in this walk
    a_check_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_chk_vld) |-> (CNT_W'(r_used) < r_issued))
        else $error("entry checked before its read was issued");

    // Write pointer moves only while a result is being loaded
    a_wp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_wp))
        else $error("write pointer moved outside the update step");

    // A loaded result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && !o_out.ready) |=> (r_state == S_DONE))
        else $error("result loaded while output stalled");

endmodule

`default_nettype wire

@@ design/recent_device_seen_table_top.sv @@
// Top level of the recent device seen table: configuration registers,
// front end, command queue and table engine. Depends on rdst_pkg, rdst_if.
//
//  channel  dir  handshake      word
//  i_in     in   valid/ready    kind, device_address, device_ident, device_type,
//                               contacted, request_flags
//  o_out    out  valid/ready    status, flags_out, entry_index, used_count
//  i_cfg    in   valid/ready    reg_index, wr_data (always ready)
//
// A command passes through the engine as a dequeue step, then a walk over
// the table entries, newest first, through the registered read (an unused
// kind walks nothing), then an update step. The entry store read port sets the
// walk rate. Synchronous reset clears the flags-valid bits, write pointer and
// all handshake state. Each side stalls independently through the queue and
// the output register.
`default_nettype none

module recent_device_seen_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rdst_in_if.sink   i_in,
    rdst_out_if.source o_out,
    rdst_cfg_if.sink  i_cfg
);
    import rdst_pkg::*;

    t_cfg r_cfg;
    logic push_vld;
    t_cmd push_cmd;
    logic push_rdy;
    logic pop_vld;
    t_cmd pop_cmd;
    logic pop_rdy;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.used_mask       <= 8'd1;
            r_cfg.visited_mask    <= 8'd2;
            r_cfg.settable_mask   <= 8'd15;
            r_cfg.type_mask       <= 8'd240;
            r_cfg.badge_type_code <= 8'd16;
            r_cfg.peer_type_code  <= 8'd32;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.reg_index))
                CFG_USED:     r_cfg.used_mask       <= i_cfg.wr_data;
                CFG_VISITED:  r_cfg.visited_mask    <= i_cfg.wr_data;
                CFG_SETTABLE: r_cfg.settable_mask   <= i_cfg.wr_data;
                CFG_TYPE:     r_cfg.type_mask       <= i_cfg.wr_data;
                CFG_BADGE:    r_cfg.badge_type_code <= i_cfg.wr_data;
                CFG_PEER:     r_cfg.peer_type_code  <= i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

    rdst_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .o_push_vld (push_vld),
        .o_push_cmd (push_cmd),
        .i_push_rdy (push_rdy)
    );

    rdst_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (push_vld),
        .i_push_cmd (push_cmd),
        .o_push_rdy (push_rdy),
        .o_pop_vld  (pop_vld),
        .o_pop_cmd  (pop_cmd),
        .i_pop_rdy  (pop_rdy)
    );

    rdst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_pop_vld (pop_vld),
        .i_pop_cmd (pop_cmd),
        .o_pop_rdy (pop_rdy),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
